FILE: hw/rtl/spq_pkg.sv
// shared types and constants for the stable priority queue
package spq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned TAG_BITS = 16;
  localparam int unsigned PRIO_W   = 4;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic [PRIO_W-1:0]   prio;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic                req_type;
    logic [PRIO_W-1:0]   entry_priority;
    logic [TAG_BITS-1:0] entry_tag;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [PRIO_W-1:0]   removed_priority;
    logic [TAG_BITS-1:0] removed_tag;
    logic                head_valid;
    logic [PRIO_W-1:0]   head_priority;
    logic [TAG_BITS-1:0] head_tag;
    logic [CNT_W-1:0]    fill_count;
  } res_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } ctrl_t;

endpackage

FILE: hw/rtl/spq_cell.sv
// one slot of the sorted chain: keeps, takes the new entry or shifts
module spq_cell (
  input  logic           clk_i,
  input  spq_pkg::ctrl_t ctrl_i,
  input  spq_pkg::entry_t new_i,
  input  logic           valid_i,
  input  logic           left_valid_i,
  input  spq_pkg::entry_t left_i,
  input  spq_pkg::entry_t right_i,
  output spq_pkg::entry_t entry_o,
  output spq_pkg::entry_t entry_next_o
);

  spq_pkg::entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (!(valid_i && (entry_q.prio <= new_i.prio))) begin
        if (left_valid_i && (left_i.prio <= new_i.prio)) begin
          entry_d = new_i;
        end else begin
          entry_d = left_i;
        end
      end
    end else if (ctrl_i.rem) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o      = entry_q;
  assign entry_next_o = entry_d;

endmodule

FILE: hw/rtl/stable_priority_queue.sv
// top level of the stable min-priority queue built as a chain of slot cells
//
// request channel: an item on req_i is taken at a rising edge with start high
// and busy low. busy is never raised, so one item can be taken every cycle.
// req_type 0 inserts entry_priority/entry_tag behind every held entry of
// lower or equal priority; req_type 1 removes the head entry.
// result channel: in the cycle after an item is taken, done_o is high for one
// cycle with res_o holding the status, the removed entry, the head entry and
// the fill count after that item. throughput 1 item/cycle, set by the row of
// slot cells, each of which decides whether to keep its entry, take the new
// entry or take a neighbor's entry.
// insert on a full queue is dropped with status full; remove on an empty
// queue reports status empty. both leave the contents unchanged.
// reset empties the queue (fill count zero) and clears done_o; slot
// contents are not cleared, only slots below the fill count are read.
// the receiver cannot stall: done_o marks each result for exactly one cycle.
module stable_priority_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::req_t req_i,
  output logic          done_o,
  output spq_pkg::res_t res_o
);

  localparam int unsigned N = spq_pkg::CAPACITY;

  logic                       accept;
  logic [spq_pkg::CNT_W-1:0]  count_q, count_d;
  logic                       is_full, is_empty;
  spq_pkg::ctrl_t             ctrl;
  spq_pkg::entry_t            new_entry;
  spq_pkg::entry_t            cell_q [N];
  spq_pkg::entry_t            cell_d [N];
  logic [N-1:0]               occ;
  spq_pkg::res_t              res_q, res_d;
  logic                       done_q;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (count_q == spq_pkg::CNT_W'(N));
  assign is_empty = (count_q == '0);

  assign ctrl.ins  = accept && !req_i.req_type && !is_full;
  assign ctrl.rem  = accept && req_i.req_type && !is_empty;
  assign new_entry = '{prio: req_i.entry_priority, tag: req_i.entry_tag};

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + spq_pkg::CNT_W'(1);
    end else if (ctrl.rem) begin
      count_d = count_q - spq_pkg::CNT_W'(1);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    spq_pkg::entry_t left, right;
    logic            left_valid;

    assign occ[i] = (spq_pkg::CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      assign left       = '{prio: '0, tag: '0};
      assign left_valid = 1'b1;
    end else begin : g_mid
      assign left       = cell_q[i-1];
      assign left_valid = occ[i-1];
    end

    if (i == N - 1) begin : g_last
      assign right = cell_q[i];
    end else begin : g_inner
      assign right = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .new_i        (new_entry),
      .valid_i      (occ[i]),
      .left_valid_i (left_valid),
      .left_i       (left),
      .right_i      (right),
      .entry_o      (cell_q[i]),
      .entry_next_o (cell_d[i])
    );
  end

  always_comb begin
    res_d                  = '0;
    res_d.status           = spq_pkg::ST_INSERTED;
    if (req_i.req_type) begin
      if (is_empty) begin
        res_d.status = spq_pkg::ST_EMPTY;
      end else begin
        res_d.status           = spq_pkg::ST_REMOVED;
        res_d.removed_priority = cell_q[0].prio;
        res_d.removed_tag      = cell_q[0].tag;
      end
    end else if (is_full) begin
      res_d.status = spq_pkg::ST_FULL;
    end
    res_d.head_valid = (count_d != '0);
    if (res_d.head_valid) begin
      res_d.head_priority = cell_d[0].prio;
      res_d.head_tag      = cell_d[0].tag;
    end
    res_d.fill_count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

FILE: hw/rtl/spq_checker.sv
// port-level checks for the stable priority queue and their binding
module spq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input spq_pkg::res_t res_o
);

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.fill_count <= spq_pkg::CNT_W'(spq_pkg::CAPACITY)))
    else $error("fill count above capacity");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.head_valid == (res_o.fill_count != '0)))
    else $error("head valid disagrees with fill count");

  a_removed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (res_o.status != spq_pkg::ST_REMOVED)) |->
      ((res_o.removed_priority == '0) && (res_o.removed_tag == '0)))
    else $error("removed fields set without a removal");

  a_item_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("item taken without a result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result without an item");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);

FILE: sim/tb.sv
// testbench for the stable min-priority queue: directed table, then random insert/remove traffic
`timescale 1ns / 100ps

module tb;
  import spq_pkg::*;

  localparam int DIR_ROWS  = 25;
  localparam int RAND_ITEMS = 1000;
  localparam int QUIET_TAIL = 100;

  typedef struct {
    req_t req;
    bit   typed;
    res_t want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic req_start;
  logic req_busy;
  req_t req_item;
  logic res_done;
  res_t res_item;

  logic [PRIO_W-1:0]   shadow_prio [CAPACITY];
  logic [TAG_BITS-1:0] shadow_tag [CAPACITY];
  int                  shadow_fill;
  res_t                expected_results [$];
  int                  mismatch_count;

  dir_row_t directed_rows [DIR_ROWS] = '{
    '{'{1'b1, 4'd0,  16'h0000}, 1'b1, '{ST_EMPTY,    4'd0, 16'h0, 1'b0, 4'd0,  16'h0000, 5'd0}},
    '{'{1'b0, 4'd15, 16'hffff}, 1'b1, '{ST_INSERTED, 4'd0, 16'h0, 1'b1, 4'd15, 16'hffff, 5'd1}},
    '{'{1'b0, 4'd0,  16'h0000}, 1'b1, '{ST_INSERTED, 4'd0, 16'h0, 1'b1, 4'd0,  16'h0000, 5'd2}},
    '{'{1'b0, 4'd0,  16'h0001}, 1'b1, '{ST_INSERTED, 4'd0, 16'h0, 1'b1, 4'd0,  16'h0000, 5'd3}},
    '{'{1'b1, 4'd9,  16'h5a5a}, 1'b1, '{ST_REMOVED,  4'd0, 16'h0, 1'b1, 4'd0,  16'h0001, 5'd2}},
    '{'{1'b0, 4'd15, 16'haaaa}, 1'b0, '0},
    '{'{1'b0, 4'd7,  16'h5555}, 1'b0, '0},
    '{'{1'b0, 4'd8,  16'h1234}, 1'b0, '0},
    '{'{1'b0, 4'd0,  16'h8000}, 1'b0, '0},
    '{'{1'b0, 4'd15, 16'h7fff}, 1'b0, '0},
    '{'{1'b0, 4'd3,  16'h0f0f}, 1'b0, '0},
    '{'{1'b0, 4'd3,  16'hf0f0}, 1'b0, '0},
    '{'{1'b0, 4'd3,  16'h00ff}, 1'b0, '0},
    '{'{1'b0, 4'd12, 16'hff00}, 1'b0, '0},
    '{'{1'b0, 4'd1,  16'h3c3c}, 1'b0, '0},
    '{'{1'b0, 4'd9,  16'hc3c3}, 1'b0, '0},
    '{'{1'b0, 4'd15, 16'h0101}, 1'b0, '0},
    '{'{1'b0, 4'd0,  16'hfffe}, 1'b0, '0},
    '{'{1'b0, 4'd6,  16'h4242}, 1'b0, '0},
    '{'{1'b0, 4'd2,  16'hbeef}, 1'b1, '{ST_FULL,     4'd0, 16'h0, 1'b1, 4'd0,  16'h0001, 5'd16}},
    '{'{1'b1, 4'd15, 16'hffff}, 1'b0, '0},
    '{'{1'b1, 4'd0,  16'h0000}, 1'b0, '0},
    '{'{1'b1, 4'd15, 16'hffff}, 1'b0, '0},
    '{'{1'b1, 4'd0,  16'h0000}, 1'b0, '0},
    '{'{1'b0, 4'd0,  16'hffff}, 1'b0, '0}
  };

  stable_priority_queue i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (req_start),
    .busy   (req_busy),
    .req_i  (req_item),
    .done_o (res_done),
    .res_o  (res_item)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic res_t queue_step(input req_t r);
    res_t o;
    int   pos;
    int   k;
    o = '0;
    if (!r.req_type) begin
      if (shadow_fill >= CAPACITY) begin
        o.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_fill && shadow_prio[pos] <= r.entry_priority) pos++;
        for (k = shadow_fill; k > pos; k--) begin
          shadow_prio[k] = shadow_prio[k-1];
          shadow_tag[k]  = shadow_tag[k-1];
        end
        shadow_prio[pos] = r.entry_priority;
        shadow_tag[pos]  = r.entry_tag;
        shadow_fill++;
        o.status = ST_INSERTED;
      end
    end else begin
      if (shadow_fill == 0) begin
        o.status = ST_EMPTY;
      end else begin
        o.status           = ST_REMOVED;
        o.removed_priority = shadow_prio[0];
        o.removed_tag      = shadow_tag[0];
        for (k = 0; k + 1 < shadow_fill; k++) begin
          shadow_prio[k] = shadow_prio[k+1];
          shadow_tag[k]  = shadow_tag[k+1];
        end
        shadow_fill--;
      end
    end
    if (shadow_fill > 0) begin
      o.head_valid    = 1'b1;
      o.head_priority = shadow_prio[0];
      o.head_tag      = shadow_tag[0];
    end
    o.fill_count = CNT_W'(shadow_fill);
    return o;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic drive_item(input req_t r, input bit typed, input res_t want);
    res_t predicted;
    req_start <= 1'b1;
    req_item  <= r;
    do @(posedge clk_i); while (req_busy !== 1'b0);
    predicted = queue_step(r);
    expected_results.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  task automatic idle_gap(input bit allow);
    if (allow && $urandom_range(3) == 0) begin
      req_start <= 1'b0;
      repeat ($urandom_range(10, 1)) @(negedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    req_start <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (expected_results.size() == 0) begin
      $error("result with no item pending");
      mismatch_count++;
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatch_count++;
    end
    if (got.removed_priority !== want.removed_priority) begin
      $error("removed_priority: expected %0d, got %0d",
             want.removed_priority, got.removed_priority);
      mismatch_count++;
    end
    if (got.removed_tag !== want.removed_tag) begin
      $error("removed_tag: expected %h, got %h", want.removed_tag, got.removed_tag);
      mismatch_count++;
    end
    if (got.head_valid !== want.head_valid) begin
      $error("head_valid: expected %0d, got %0d", want.head_valid, got.head_valid);
      mismatch_count++;
    end
    if (got.head_priority !== want.head_priority) begin
      $error("head_priority: expected %0d, got %0d", want.head_priority, got.head_priority);
      mismatch_count++;
    end
    if (got.head_tag !== want.head_tag) begin
      $error("head_tag: expected %h, got %h", want.head_tag, got.head_tag);
      mismatch_count++;
    end
    if (got.fill_count !== want.fill_count) begin
      $error("fill_count: expected %0d, got %0d", want.fill_count, got.fill_count);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_done === 1'b1) check_result(res_item);
  end

  initial begin
    req_t r;
    int   ins_pct;
    int   prio_mode;
    int   block_left;
    bit   idle_on;
    rst_ni         = 1'b0;
    req_start      = 1'b0;
    req_item       = '0;
    shadow_fill    = 0;
    mismatch_count = 0;
    ins_pct        = 50;
    prio_mode      = 0;
    block_left     = 0;
    idle_on        = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      drive_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      idle_gap(i % 2);
    end
    wait_for_results();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (block_left == 0) begin
        block_left = $urandom_range(48, 16);
        case ($urandom_range(3))
          0:       ins_pct = 20;
          1:       ins_pct = 50;
          2:       ins_pct = 80;
          default: ins_pct = 95;
        endcase
        prio_mode = $urandom_range(2);
        idle_on   = $urandom_range(1);
      end
      block_left--;
      r.req_type = ($urandom_range(99) >= ins_pct);
      case (prio_mode)
        0:       r.entry_priority = $urandom_range(15);
        1:       r.entry_priority = $urandom_range(3);
        default: r.entry_priority = $urandom_range(15, 12);
      endcase
      r.entry_tag = $urandom_range(16'hffff);
      drive_item(r, 1'b0, '0);
      if (i == RAND_ITEMS / 2) wait_for_results();
      idle_gap(idle_on && i < RAND_ITEMS - QUIET_TAIL);
    end
    wait_for_results();
    repeat (4) @(posedge clk_i);

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
